@@ hw/rtl/infix_expression_evaluator_assert.svh @@
// Assertion macros for the evaluator's port-level checker
`ifndef INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// same-cycle implication, clocked on aclk, off during reset
`define IFX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define IFX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ifx_pkg.sv @@
// Shared types, constants and character codes for the expression evaluator
package ifx_pkg;

    localparam int NESTING_DEPTH_DEFAULT = 16;
    localparam int VALUE_BITS            = 32;
    localparam int POSITION_BITS         = 16;

    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;

    typedef logic [VALUE_BITS-1:0]    value_t;
    typedef logic [POSITION_BITS-1:0] pos_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_SYNTAX = 2'd1,
        STATUS_DEPTH  = 2'd2
    } status_t;

    typedef struct packed {
        logic    expect_operand;
        value_t  level_sum;
        value_t  level_product;
        pos_t    char_count;
        status_t error_code;
        pos_t    first_error_position;
    } eval_state_t;

    typedef struct packed {
        status_t status;
        value_t  value;
        pos_t    error_position;
    } eval_result_t;

    localparam eval_state_t STATE_RESET = '{
        expect_operand:       1'b1,
        level_sum:            '0,
        level_product:        VALUE_BITS'(1),
        char_count:           '0,
        error_code:           STATUS_OK,
        first_error_position: '0
    };

endpackage

@@ hw/rtl/ifx_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data
module ifx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/ifx_step.sv @@
// Next-state and result logic for one character or end marker
module ifx_step import ifx_pkg::*; #(
    parameter int MAX_NESTING = NESTING_DEPTH_DEFAULT,
    localparam int LW         = $clog2(MAX_NESTING + 1)
) (
    input  logic [7:0]    in_char,
    input  logic          in_end,
    input  eval_state_t   cur,
    input  logic [LW-1:0] level_in,
    input  value_t        top_sum,
    input  value_t        top_product,
    output eval_state_t   nxt,
    output logic [LW-1:0] level_out,
    output logic          push,
    output eval_result_t  result
);

    pos_t    count_sat;
    value_t  total;
    value_t  digit_product;
    value_t  pop_product;
    logic    is_digit;
    logic [3:0] digit;
    status_t res_status;
    pos_t    res_pos;

    assign count_sat     = (cur.char_count != '1) ? cur.char_count + 1'b1 : cur.char_count;
    assign total         = cur.level_sum + cur.level_product;
    assign is_digit      = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
    assign digit         = 4'(in_char - CHAR_ZERO);
    assign digit_product = cur.level_product * {{(VALUE_BITS-4){1'b0}}, digit};
    assign pop_product   = top_product * total;

    always_comb begin
        nxt        = cur;
        level_out  = level_in;
        push       = 1'b0;
        result     = '0;
        res_status = cur.error_code;
        res_pos    = cur.first_error_position;
        if (in_end) begin
            if (cur.error_code == STATUS_OK && (cur.expect_operand || level_in != '0)) begin
                res_status = STATUS_SYNTAX;
                res_pos    = count_sat;
            end
            result.status         = res_status;
            result.value          = (res_status == STATUS_OK) ? total : '0;
            result.error_position = (res_status != STATUS_OK) ? res_pos : '0;
            nxt       = STATE_RESET;
            level_out = '0;
        end else begin
            nxt.char_count = count_sat;
            if (cur.error_code == STATUS_OK) begin
                if (cur.expect_operand) begin
                    if (is_digit) begin
                        nxt.level_product  = digit_product;
                        nxt.expect_operand = 1'b0;
                    end else if (in_char == CHAR_LPAREN) begin
                        if (level_in == LW'(MAX_NESTING)) begin
                            nxt.error_code           = STATUS_DEPTH;
                            nxt.first_error_position = count_sat;
                        end else begin
                            push              = 1'b1;
                            level_out         = level_in + 1'b1;
                            nxt.level_sum     = '0;
                            nxt.level_product = VALUE_BITS'(1);
                        end
                    end else begin
                        nxt.error_code           = STATUS_SYNTAX;
                        nxt.first_error_position = count_sat;
                    end
                end else begin
                    if (in_char == CHAR_PLUS) begin
                        nxt.level_sum      = total;
                        nxt.level_product  = VALUE_BITS'(1);
                        nxt.expect_operand = 1'b1;
                    end else if (in_char == CHAR_STAR) begin
                        nxt.expect_operand = 1'b1;
                    end else if (in_char == CHAR_RPAREN && level_in != '0) begin
                        level_out         = level_in - 1'b1;
                        nxt.level_sum     = top_sum;
                        nxt.level_product = pop_product;
                    end else begin
                        nxt.error_code           = STATUS_SYNTAX;
                        nxt.first_error_position = count_sat;
                    end
                end
            end
        end
    end

endmodule

@@ hw/rtl/infix_expression_evaluator.sv @@
// An end marker is held in the input register, then its result is written into the result register.
// Throughput: one character per cycle; only the end marker waits on a full result register.
// A ')' closes a level with one add and one 32x32 multiply in the evaluation cycle.
// Reset (aresetn low, synchronous) clears the pipeline valids and the evaluator state.
// The nesting stack RAM is not cleared; entries are always pushed before popped.
module infix_expression_evaluator import ifx_pkg::*; #(
    parameter int MAX_NESTING = NESTING_DEPTH_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] char_code
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [VALUE_BITS+POSITION_BITS-1:0] m_tdata, // [31:0] value, [47:32] error_position
    output logic [1:0]                      m_tuser    // [1:0] status
);

    localparam int LW = $clog2(MAX_NESTING + 1);
    localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
    localparam int SW = 2 * VALUE_BITS;

    logic          in_valid_reg;
    logic [7:0]    in_char_reg;
    logic          in_end_reg;
    eval_state_t   state_reg, state_next;
    logic [LW-1:0] level_reg, level_next;
    logic          out_valid_reg;
    eval_result_t  out_result_reg, step_result;
    logic          byp_reg;
    logic [SW-1:0] byp_data_reg;

    logic          fire;
    logic          out_free;
    logic          push;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [SW-1:0] wr_data;
    logic [LW-1:0] rd_level;
    logic [AW-1:0] rd_addr;
    logic [SW-1:0] rd_data;
    logic [SW-1:0] top_data;

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && (!in_end_reg || out_free);
    assign s_tready = !in_valid_reg || fire;

    ifx_step #(
        .MAX_NESTING(MAX_NESTING)
    ) u_step (
        .in_char    (in_char_reg),
        .in_end     (in_end_reg),
        .cur        (state_reg),
        .level_in   (level_reg),
        .top_sum    (top_data[SW-1:VALUE_BITS]),
        .top_product(top_data[VALUE_BITS-1:0]),
        .nxt        (state_next),
        .level_out  (level_next),
        .push       (push),
        .result     (step_result)
    );

    assign wr_en    = fire && push;
    assign wr_addr  = level_reg[AW-1:0];
    assign wr_data  = {state_reg.level_sum, state_reg.level_product};
    assign rd_level = (fire ? level_next : level_reg) - 1'b1;
    assign rd_addr  = rd_level[AW-1:0];
    assign top_data = byp_reg ? byp_data_reg : rd_data;

    ifx_ram #(
        .WIDTH(SW),
        .DEPTH(MAX_NESTING)
    ) u_stack (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
            level_reg     <= '0;
            byp_reg       <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fire) begin
                state_reg <= state_next;
                level_reg <= level_next;
            end
            if (fire && in_end_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (fire && in_end_reg) begin
            out_result_reg <= step_result;
        end
        byp_data_reg <= wr_data;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_result_reg.error_position, out_result_reg.value};
    assign m_tuser  = out_result_reg.status;

endmodule

@@ hw/rtl/ifx_checker.sv @@
// Port-level checker for the expression evaluator, bound to the top level
`include "infix_expression_evaluator_assert.svh"

module ifx_checker import ifx_pkg::*; (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [VALUE_BITS+POSITION_BITS-1:0] m_tdata,
    input logic [1:0]                          m_tuser
);

    `IFX_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `IFX_ASSERT_NOW(a_ok_no_position, m_tvalid && m_tuser == STATUS_OK, m_tdata[VALUE_BITS+POSITION_BITS-1:VALUE_BITS] == '0, "position reported on good expression")
    `IFX_ASSERT_NOW(a_error_shape, m_tvalid && m_tuser != STATUS_OK, m_tdata[VALUE_BITS-1:0] == '0 && m_tdata[VALUE_BITS+POSITION_BITS-1:VALUE_BITS] != '0, "error result malformed")

endmodule

bind infix_expression_evaluator ifx_checker u_ifx_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

@@ test/infix_expression_evaluator_checker.sv @@
// Checker for the expression evaluator: watches both channels, predicts results and compares.
`timescale 1ns / 100ps

module infix_expression_evaluator_checker import ifx_pkg::*; #(
    parameter int MAX_NESTING = NESTING_DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] char_code
    input  logic                                s_tlast,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [VALUE_BITS+POSITION_BITS-1:0] m_tdata,   // [31:0] value, [47:32] error_position
    input  logic [1:0]                          m_tuser,   // [1:0] status
    output int unsigned                         pending,
    output int unsigned                         checked,
    output int unsigned                         fail_count
);

    logic         want_operand;
    int           depth;
    value_t       run_sum;
    value_t       term_product;
    value_t       sum_stack [MAX_NESTING];
    value_t       product_stack [MAX_NESTING];
    pos_t         seen_chars;
    status_t      first_status;
    pos_t         first_pos;
    eval_result_t result_q [$];

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        fail_count++;
    endtask

    // stacks keep their contents across expressions, like the block's RAM
    task automatic clear_levels();
        want_operand = 1'b1;
        depth        = 0;
        run_sum      = '0;
        term_product = value_t'(1);
        seen_chars   = '0;
        first_status = STATUS_OK;
        first_pos    = '0;
    endtask

    task automatic note_error(input status_t code, input pos_t where);
        if (first_status == STATUS_OK) begin
            first_status = code;
            first_pos    = where;
        end
    endtask

    task automatic evaluate_char(input logic [7:0] c, input logic last);
        eval_result_t res;
        pos_t         end_pos;
        value_t       inner;
        if (last) begin
            end_pos = (seen_chars != '1) ? pos_t'(seen_chars + 1'b1) : seen_chars;
            if (want_operand || depth != 0)
                note_error(STATUS_SYNTAX, end_pos);
            res.status         = first_status;
            res.value          = (first_status == STATUS_OK) ? run_sum + term_product : '0;
            res.error_position = (first_status == STATUS_OK) ? '0 : first_pos;
            result_q.push_back(res);
            clear_levels();
        end else begin
            if (seen_chars != '1)
                seen_chars++;
            if (first_status == STATUS_OK) begin
                if (want_operand) begin
                    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                        term_product = term_product * value_t'(c - CHAR_ZERO);
                        want_operand = 1'b0;
                    end else if (c == CHAR_LPAREN) begin
                        if (depth >= MAX_NESTING) begin
                            note_error(STATUS_DEPTH, seen_chars);
                        end else begin
                            sum_stack[depth]     = run_sum;
                            product_stack[depth] = term_product;
                            depth++;
                            run_sum      = '0;
                            term_product = value_t'(1);
                        end
                    end else begin
                        note_error(STATUS_SYNTAX, seen_chars);
                    end
                end else begin
                    if (c == CHAR_PLUS) begin
                        run_sum      = run_sum + term_product;
                        term_product = value_t'(1);
                        want_operand = 1'b1;
                    end else if (c == CHAR_STAR) begin
                        want_operand = 1'b1;
                    end else if (c == CHAR_RPAREN && depth != 0) begin
                        inner = run_sum + term_product;
                        depth--;
                        run_sum      = sum_stack[depth];
                        term_product = product_stack[depth] * inner;
                    end else begin
                        note_error(STATUS_SYNTAX, seen_chars);
                    end
                end
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        eval_result_t want;
        if (!aresetn) begin
            clear_levels();
            result_q.delete();
            checked    = 0;
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                checked++;
                if (result_q.size() == 0) begin
                    report($sformatf("result %0d arrived with nothing expected", checked));
                end else begin
                    want = result_q.pop_front();
                    if (m_tuser !== want.status)
                        report($sformatf("result %0d status %0d, expected %0d",
                                         checked, m_tuser, want.status));
                    if (m_tdata[VALUE_BITS-1:0] !== want.value)
                        report($sformatf("result %0d value %h, expected %h",
                                         checked, m_tdata[VALUE_BITS-1:0], want.value));
                    if (m_tdata[VALUE_BITS +: POSITION_BITS] !== want.error_position)
                        report($sformatf("result %0d error_position %0d, expected %0d", checked,
                                         m_tdata[VALUE_BITS +: POSITION_BITS],
                                         want.error_position));
                end
            end
            if (s_tvalid && s_tready)
                evaluate_char(s_tdata, s_tlast);
        end
        pending <= result_q.size();
    end

endmodule

@@ test/infix_expression_evaluator_tb.sv @@
// Testbench top for the expression evaluator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module infix_expression_evaluator_tb;
    import ifx_pkg::*;

    logic                                aclk     = 1'b0;
    logic                                aresetn  = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [7:0]                          s_tdata  = '0;
    logic                                s_tlast  = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [VALUE_BITS+POSITION_BITS-1:0] m_tdata;
    logic [1:0]                          m_tuser;

    int unsigned pending;
    int unsigned checked;
    int unsigned fail_count;

    logic       quiet        = 1'b0;
    int         phase_cycles = 0;
    int         ready_hold   = 0;
    int         n_chars      = 0;
    int         n_exprs      = 0;
    logic [7:0] text_q [$];

    infix_expression_evaluator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    infix_expression_evaluator_checker eval_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .pending    (pending),
        .checked    (checked),
        .fail_count (fail_count)
    );

    always #10 aclk = ~aclk;

    initial begin
        #40_000_000;
        $display("timeout: %0d results still outstanding", pending);
        $display("infix_expression_evaluator_tb failed");
        $finish;
    end

    // mostly short gaps, a few long ones, none during quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (phase_cycles == 600) begin
            phase_cycles <= 0;
            quiet        <= ($urandom_range(0, 3) == 0);
        end else begin
            phase_cycles <= phase_cycles + 1;
        end
        if (ready_hold > 0) begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready   <= 1'b1;
            ready_hold <= pick_gap();
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // sends the buffered characters, then an end marker with a junk byte
    task automatic send_text();
        foreach (text_q[i]) send_char(text_q[i], 1'b0);
        send_char(8'($urandom_range(0, 255)), 1'b1);
        n_chars += text_q.size();
        n_exprs++;
    endtask

    task automatic send_string(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
        send_text();
    endtask

    // well-formed expression; deep mode opens parentheses eagerly
    task automatic build_well_formed(input int max_depth, input bit deep, input int target);
        int open;
        bit operand;
        int r;
        open    = 0;
        operand = 1'b1;
        text_q.delete();
        while (1) begin
            if (operand) begin
                r = $urandom_range(0, 3);
                if (open < max_depth && (deep ? r != 0 : r == 0)) begin
                    text_q.push_back(CHAR_LPAREN);
                    open++;
                end else begin
                    text_q.push_back(($urandom_range(0, 2) == 0) ? CHAR_NINE :
                                     8'(CHAR_ZERO + $urandom_range(0, 9)));
                    operand = 1'b0;
                end
            end else if (text_q.size() >= target) begin
                if (open == 0)
                    break;
                text_q.push_back(CHAR_RPAREN);
                open--;
            end else begin
                r = $urandom_range(0, 9);
                if (r < 4) begin
                    text_q.push_back(CHAR_PLUS);
                    operand = 1'b1;
                end else if (r < 8 || open == 0) begin
                    text_q.push_back(CHAR_STAR);
                    operand = 1'b1;
                end else begin
                    text_q.push_back(CHAR_RPAREN);
                    open--;
                end
            end
        end
    endtask

    initial begin
        int         r;
        int         pos;
        int         random_chars;
        logic [7:0] tokens [6];
        tokens = '{CHAR_PLUS, CHAR_STAR, CHAR_LPAREN, CHAR_RPAREN, CHAR_ZERO, CHAR_NINE};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_string("9");
        send_string("0");
        send_string("1+2*3");
        send_string("(1+2)*3");
        send_string("((9))");
        send_string("9*9*9*9*9*9*9*9*9*9*9");
        send_string("");
        send_string("1+a+((");
        send_string("+1");
        send_string("12");
        send_string("1(");
        send_string("1)");
        send_string("*");
        send_string("1+");
        send_string("(1");
        text_q = {8'h00};
        send_text();
        text_q = {CHAR_NINE, 8'hFF};
        send_text();
        send_string("((((((((((((((((7))))))))))))))))");
        send_string("(((((((((((((((((1)))))))))))))))))");

        random_chars = 0;
        while (random_chars < 2000) begin
            r = $urandom_range(0, 9);
            if (r < 9) begin
                if ($urandom_range(0, 9) == 0)
                    build_well_formed($urandom_range(14, 17), 1'b1, $urandom_range(1, 6));
                else
                    build_well_formed($urandom_range(0, 4), 1'b0, $urandom_range(1, 25));
                if (r >= 7) begin
                    pos = $urandom_range(0, text_q.size() - 1);
                    case ($urandom_range(0, 3))
                        0: text_q[pos] = 8'($urandom_range(0, 255));
                        1: while (text_q.size() > pos) text_q.pop_back();
                        2: text_q.insert(pos, tokens[$urandom_range(0, 5)]);
                        default: text_q.push_back(CHAR_RPAREN);
                    endcase
                end
            end else begin
                text_q.delete();
                repeat ($urandom_range(0, 12)) text_q.push_back(8'($urandom_range(0, 255)));
            end
            random_chars += text_q.size() + 1;
            send_text();
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d characters in %0d expressions sent, %0d results checked",
                 n_chars, n_exprs, checked);
        $display("covered valid, malformed, too-deep and wrapping expressions under stalls");
        if (fail_count == 0)
            $display("infix_expression_evaluator_tb passed");
        else
            $display("infix_expression_evaluator_tb failed");
        $finish;
    end

endmodule

@@ infix_expression_evaluator.f @@
+incdir+hw/rtl
hw/rtl/ifx_pkg.sv
hw/rtl/ifx_ram.sv
hw/rtl/ifx_step.sv
hw/rtl/infix_expression_evaluator.sv
hw/rtl/ifx_checker.sv
test/infix_expression_evaluator_checker.sv
test/infix_expression_evaluator_tb.sv
